FILE: rtl/core/pfa_pkg.sv
// Shared constants, codes, types and helpers of the page frame allocator.
package pfa_pkg;

    // Default geometry
    localparam int PAGE_COUNT_DEF = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    // Register reset values
    localparam logic [31:0] REGION_BASE_RST    = 32'h8000_0000;
    localparam logic [15:0] RESERVED_PAGES_RST = 16'd257;

    // Configuration register indexes
    localparam logic CFG_REGION_BASE    = 1'b0;
    localparam logic CFG_RESERVED_PAGES = 1'b1;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_NULL       = 3'd2;
    localparam logic [2:0] ST_OUTSIDE    = 3'd3;
    localparam logic [2:0] ST_MISALIGNED = 3'd4;

    // Update of one word's full flag in the summary vector
    typedef struct packed {
        logic en;
        logic full;
    } full_upd_t;

    // Position of the lowest clear bit of a map word (0 if none)
    function automatic logic [5:0] lowest_zero64(input logic [63:0] v);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!v[i])
            begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/core/pfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/pfa_search.sv
// Summary vector of full map words and two-level search for the lowest non-full word.
module pfa_search #(
    parameter int MAP_WORDS = 512,
    parameter int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pfa_pkg::full_upd_t      upd,
    input  logic [WORD_AW-1:0]      upd_word,
    output logic                    any_free,
    output logic [WORD_AW-1:0]      free_word
);

    localparam int N_GRP  = (MAP_WORDS + 63) / 64;
    localparam int GRP_AW = (N_GRP > 1) ? $clog2(N_GRP) : 1;

    logic [MAP_WORDS-1:0] full_reg;
    logic [N_GRP*64-1:0]  full_pad;
    logic [N_GRP-1:0]     grp_free_reg;
    logic [N_GRP-1:0]     grp_free_next;
    logic [5:0]           grp_low_reg  [N_GRP];
    logic [5:0]           grp_low_next [N_GRP];
    logic [GRP_AW-1:0]    grp_sel;

    // one full flag per map word, all clear after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (upd.en)
        begin
            full_reg[upd_word] <= upd.full;
        end
    end

    // words past the end of the map count as full
    always_comb
    begin
        full_pad                = '1;
        full_pad[MAP_WORDS-1:0] = full_reg;
    end

    // first level: per group of 64 words, any free word and the lowest one
    always_comb
    begin
        for (int g = 0; g < N_GRP; g++)
        begin
            grp_free_next[g] = ~&full_pad[g*64 +: 64];
            grp_low_next[g]  = pfa_pkg::lowest_zero64(full_pad[g*64 +: 64]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_free_reg <= '0;
        end
        else
        begin
            grp_free_reg <= grp_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_low_reg <= grp_low_next;
    end

    // second level: lowest group holding a free word
    always_comb
    begin
        grp_sel = '0;
        for (int g = N_GRP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                grp_sel = GRP_AW'(g);
            end
        end
    end

    assign any_free  = |grp_free_reg;
    assign free_word = WORD_AW'({grp_sel, grp_low_reg[grp_sel]});

endmodule

FILE: rtl/core/bitmap_page_frame_allocator_top.sv
// Top level of the bitmap page frame allocator: command sequencer, map RAM and result port.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------------
//  s        | in        | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: free_addr
//  m        | out       | m_tvalid/m_tready  | m_tuser: status; m_tdata: page_addr
//  cfg      | in        | cfg_we             | cfg_index, cfg_wdata (no read-back)
//
// Allocate and free run through accept, search or address check,
// read-modify-write of one map word and result load; a failed check or a full
// map skips the read-modify-write. Init sweeps the map RAM one word a cycle.
// After reset the same sweep clears all MAP_WORDS words of the RAM (512 at the
// default size) before s_tready rises. A stalled output holds the sequencer in
// its result step; one command is in flight at a time.
module bitmap_page_frame_allocator_top #(
    parameter int PAGE_COUNT = pfa_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // command word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] free_addr
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] page_addr
    output logic [2:0]  m_tuser,   // [2:0] status
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int MAP_WORDS = (PAGE_COUNT + 63) / 64;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PIW       = WORD_AW + 6;
    localparam int NW        = (PIW + 1 > 17) ? PIW + 1 : 17;
    localparam logic [63:0] SPAN = 64'(PAGE_COUNT) << PAGE_SHIFT;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FIND  = 7'b0000100,
        S_FCHK  = 7'b0001000,
        S_MOD   = 7'b0010000,
        S_SWEEP = 7'b0100000,
        S_RES   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        base_reg;
    logic [15:0]        rsv_reg;
    logic [1:0]         cmd_reg, cmd_next;
    logic [31:0]        addr_reg, addr_next;
    logic [WORD_AW-1:0] word_reg, word_next;
    logic [5:0]         bit_reg, bit_next;
    logic [PIW-1:0]     idx_reg, idx_next;
    logic [2:0]         status_reg, status_next;
    logic [WORD_AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_addr_reg, out_addr_next;
    logic [2:0]         out_status_reg, out_status_next;

    // map RAM and search
    logic               ram_we, ram_re;
    logic [WORD_AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;
    pfa_pkg::full_upd_t upd;
    logic [WORD_AW-1:0] upd_word;
    logic               any_free;
    logic [WORD_AW-1:0] free_word;

    // datapath helpers
    logic               s_fire;
    logic [NW-1:0]      rsv_ext, n_clamped;
    logic [NW-1:0]      sweep_lo, sweep_rem;
    logic               sweep_full, sweep_last;
    logic [63:0]        sweep_word;
    logic [32:0]        free_off;
    logic               free_outside, free_misaligned;
    logic [PIW-1:0]     free_idx;
    logic [5:0]         alloc_bit;
    logic [PIW-1:0]     alloc_idx;
    logic               alloc_in_range;
    logic [31:0]        alloc_addr;

    pfa_ram #(
        .WIDTH (64),
        .DEPTH (MAP_WORDS),
        .AW    (WORD_AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfa_search #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_AW   (WORD_AW)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .upd_word  (upd_word),
        .any_free  (any_free),
        .free_word (free_word)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= pfa_pkg::REGION_BASE_RST;
            rsv_reg  <= pfa_pkg::RESERVED_PAGES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfa_pkg::CFG_REGION_BASE:    base_reg <= cfg_wdata;
                pfa_pkg::CFG_RESERVED_PAGES: rsv_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // reserved count clamped to the map size
    assign rsv_ext   = NW'(rsv_reg);
    assign n_clamped = (rsv_ext > NW'(PAGE_COUNT)) ? NW'(PAGE_COUNT) : rsv_ext;

    // sweep word: full, partial or empty depending on the reserved count
    assign sweep_lo   = NW'(sweep_cnt_reg) << 6;
    assign sweep_rem  = n_reg - sweep_lo;
    assign sweep_full = (n_reg >= sweep_lo + NW'(64));
    assign sweep_last = (sweep_cnt_reg == WORD_AW'(MAP_WORDS - 1));
    always_comb
    begin
        if (sweep_full)
        begin
            sweep_word = '1;
        end
        else if (n_reg > sweep_lo)
        begin
            sweep_word = ~({64{1'b1}} << sweep_rem[5:0]);
        end
        else
        begin
            sweep_word = '0;
        end
    end

    // free address checks: region by offset with borrow, then alignment
    assign free_off        = {1'b0, addr_reg} - {1'b0, base_reg};
    assign free_outside    = free_off[32] || ({31'b0, free_off} >= SPAN);
    assign free_misaligned = |addr_reg[PAGE_SHIFT-1:0];
    assign free_idx        = PIW'(free_off[31:0] >> PAGE_SHIFT);

    // allocation: lowest clear bit of the word read back
    assign alloc_bit      = pfa_pkg::lowest_zero64(ram_rdata);
    assign alloc_idx      = {word_reg, alloc_bit};
    assign alloc_in_range = ({1'b0, alloc_idx} < (PIW + 1)'(PAGE_COUNT));
    assign alloc_addr     = base_reg + 32'(64'(idx_reg) << PAGE_SHIFT);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = word_reg;
        upd             = '{en: 1'b0, full: 1'b0};
        upd_word        = word_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR, S_SWEEP:
            begin
                ram_we         = 1'b1;
                ram_waddr      = sweep_cnt_reg;
                ram_wdata      = sweep_word;
                upd            = '{en: 1'b1, full: sweep_full};
                upd_word       = sweep_cnt_reg;
                sweep_cnt_next = sweep_cnt_reg + WORD_AW'(1);
                if (sweep_last)
                begin
                    sweep_cnt_next = '0;
                    state_next     = (state_reg == S_CLEAR) ? S_IDLE : S_RES;
                end
            end
            S_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next    = s_tuser;
                    addr_next   = s_tdata;
                    status_next = pfa_pkg::ST_OK;
                    case (s_tuser)
                        pfa_pkg::CMD_ALLOC: state_next = S_FIND;
                        pfa_pkg::CMD_FREE:  state_next = S_FCHK;
                        pfa_pkg::CMD_INIT:
                        begin
                            n_next         = n_clamped;
                            sweep_cnt_next = '0;
                            state_next     = S_SWEEP;
                        end
                        default:            state_next = S_RES;
                    endcase
                end
            end
            S_FIND:
            begin
                if (any_free)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = free_word;
                    word_next  = free_word;
                    state_next = S_MOD;
                end
                else
                begin
                    status_next = pfa_pkg::ST_FULL;
                    state_next  = S_RES;
                end
            end
            S_FCHK:
            begin
                if (addr_reg == 32'd0)
                begin
                    status_next = pfa_pkg::ST_NULL;
                    state_next  = S_RES;
                end
                else if (free_outside)
                begin
                    status_next = pfa_pkg::ST_OUTSIDE;
                    state_next  = S_RES;
                end
                else if (free_misaligned)
                begin
                    status_next = pfa_pkg::ST_MISALIGNED;
                    state_next  = S_RES;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = WORD_AW'(free_idx >> 6);
                    word_next  = WORD_AW'(free_idx >> 6);
                    bit_next   = free_idx[5:0];
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                state_next = S_RES;
                if (cmd_reg == pfa_pkg::CMD_ALLOC)
                begin
                    idx_next = alloc_idx;
                    if (alloc_in_range)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | (64'd1 << alloc_bit);
                        upd       = '{en: 1'b1, full: &(ram_rdata | (64'd1 << alloc_bit))};
                    end
                    else
                    begin
                        status_next = pfa_pkg::ST_FULL;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(64'd1 << bit_reg);
                    upd       = '{en: 1'b1, full: 1'b0};
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = ((cmd_reg == pfa_pkg::CMD_ALLOC) &&
                                       (status_reg == pfa_pkg::ST_OK)) ? alloc_addr : 32'd0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_cnt_reg <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    // map RAM is only written by the sweep or the read-modify-write step
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_SWEEP || state_reg == S_MOD))
        else $error("map RAM written outside sweep or modify step");

    // the word picked by the search must have a clear bit when read back
    a_alloc_word_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && cmd_reg == pfa_pkg::CMD_ALLOC) |-> !(&ram_rdata))
        else $error("allocation read a full map word");

    // the reset clearing pass runs once
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clearing pass re-entered");

    // a result word carries a defined status, and an address only when ok
    a_result_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= pfa_pkg::ST_MISALIGNED) &&
                     (m_tuser == pfa_pkg::ST_OK || m_tdata == 32'd0))
        else $error("result status out of range or address with failure");
`endif

endmodule

FILE: test/page_alloc_checker.sv
// Checker for the page frame allocator: predicts each result word and compares it.
`timescale 1ns / 1ps

module page_alloc_checker #(
    parameter int PAGE_COUNT = pfa_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    localparam int MAP_WORDS = (PAGE_COUNT + 63) / 64;

    typedef struct packed {
        logic [31:0] page_addr;
        logic [2:0]  status;
    } page_result_t;

    // Shadow copy of the used map and registers
    logic [63:0]  used_map [MAP_WORDS];
    logic [31:0]  region_base;
    logic [15:0]  reserved_pages;
    page_result_t expected_results [$];
    page_result_t want;

    // Lowest free page index, -1 when the map is full
    function automatic int lowest_free_page();
        int idx;
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            if (used_map[w] != '1)
            begin
                for (int b = 0; b < 64; b++)
                begin
                    if (!used_map[w][b])
                    begin
                        idx = w * 64 + b;
                        return (idx < PAGE_COUNT) ? idx : -1;
                    end
                end
            end
        end
        return -1;
    endfunction

    // Init: clear the map, then mark the reserved pages
    function automatic void clear_and_reserve();
        int n;
        n = reserved_pages;
        if (n > PAGE_COUNT)
        begin
            n = PAGE_COUNT;
        end
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            if (w * 64 + 64 <= n)
            begin
                used_map[w] = '1;
            end
            else if (w * 64 < n)
            begin
                used_map[w] = (64'd1 << (n - w * 64)) - 64'd1;
            end
            else
            begin
                used_map[w] = '0;
            end
        end
    endfunction

    // Apply one command to the shadow map and return its result word
    function automatic page_result_t run_command(input logic [1:0] cmd, input logic [31:0] addr);
        page_result_t     r;
        longint unsigned  lo;
        longint unsigned  hi;
        longint unsigned  a;
        int               idx;
        r = '0;
        r.status = pfa_pkg::ST_OK;
        case (cmd)
            pfa_pkg::CMD_ALLOC:
            begin
                idx = lowest_free_page();
                if (idx < 0)
                begin
                    r.status = pfa_pkg::ST_FULL;
                end
                else
                begin
                    used_map[idx / 64][idx % 64] = 1'b1;
                    r.page_addr = region_base + 32'(longint'(idx) << PAGE_SHIFT);
                end
            end
            pfa_pkg::CMD_FREE:
            begin
                lo = region_base;
                hi = lo + (longint'(PAGE_COUNT) << PAGE_SHIFT);
                a  = addr;
                if (a == 0)
                begin
                    r.status = pfa_pkg::ST_NULL;
                end
                else if (a < lo || a >= hi)
                begin
                    r.status = pfa_pkg::ST_OUTSIDE;
                end
                else if ((a & ((64'd1 << PAGE_SHIFT) - 64'd1)) != 0)
                begin
                    r.status = pfa_pkg::ST_MISALIGNED;
                end
                else
                begin
                    idx = int'((a - lo) >> PAGE_SHIFT);
                    used_map[idx / 64][idx % 64] = 1'b0;
                end
            end
            pfa_pkg::CMD_INIT:
            begin
                clear_and_reserve();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Track registers and commands, compare result words in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                used_map[w] = '0;
            end
            region_base    = pfa_pkg::REGION_BASE_RST;
            reserved_pages = pfa_pkg::RESERVED_PAGES_RST;
            expected_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pfa_pkg::CFG_REGION_BASE)
                begin
                    region_base = cfg_wdata;
                end
                else
                begin
                    reserved_pages = cfg_wdata[15:0];
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(run_command(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, page_addr %h status %0d",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.page_addr !== m_tdata)
                    begin
                        $display("%0t: page_addr mismatch, expected %h, actual %h",
                                 $time, want.page_addr, m_tdata);
                        fail_count++;
                    end
                    if (want.status !== m_tuser)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top for the page frame allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int         PAGE_COUNT   = pfa_pkg::PAGE_COUNT_DEF;
    localparam int         PAGE_SHIFT   = pfa_pkg::PAGE_SHIFT_DEF;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_WORDS = 1950;
    localparam int         STALL_LIMIT  = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          idle_cycles;
    int          random_words;
    logic [31:0] cur_base;
    logic [15:0] cur_resv;

    bitmap_page_frame_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    page_alloc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one command word and hold it until accepted
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] addr);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= addr;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // Stop sending and let every outstanding result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers back to back
    task automatic write_regs(input logic [31:0] base, input logic [31:0] resv_word);
        cfg_we    <= 1'b1;
        cfg_index <= pfa_pkg::CFG_REGION_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= pfa_pkg::CFG_RESERVED_PAGES;
        cfg_wdata <= resv_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_base = base;
        cur_resv = resv_word[15:0];
    endtask

    // Free address: mostly pages near the allocation front, plus every bad kind
    function automatic logic [31:0] pick_free_addr();
        int          n;
        int          lo_i;
        int          hi_i;
        int          r;
        logic [31:0] pg;
        n    = (cur_resv > PAGE_COUNT) ? PAGE_COUNT : cur_resv;
        lo_i = (n > 20) ? n - 20 : 0;
        hi_i = (n + 150 < PAGE_COUNT) ? n + 150 : PAGE_COUNT - 1;
        if (lo_i > hi_i)
        begin
            lo_i = hi_i;
        end
        pg = cur_base + (32'($urandom_range(lo_i, hi_i)) << PAGE_SHIFT);
        r  = $urandom_range(0, 99);
        if (r < 60)
            return pg;
        else if (r < 70)
            return pg | 32'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
        else if (r < 78)
            return cur_base - (32'($urandom_range(1, 8)) << PAGE_SHIFT);
        else if (r < 85)
            return cur_base + (32'(PAGE_COUNT + $urandom_range(0, 8)) << PAGE_SHIFT);
        else if (r < 90)
            return 32'd0;
        else
            return $urandom;
    endfunction

    initial
    begin
        logic [31:0] base;
        logic [15:0] resv;
        int          len;
        int          r;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = 1'b0;
        cfg_wdata    = '0;
        idle_cycles  = 0;
        random_words = 0;
        tx_idle_pct  = 19;
        rx_idle_pct  = 58;
        cur_base     = pfa_pkg::REGION_BASE_RST;
        cur_resv     = pfa_pkg::RESERVED_PAGES_RST;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // Map clear sweep after reset
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);

        // Reset registers, map not initialized: page 0 is free
        send_word(pfa_pkg::CMD_ALLOC, 32'd0);
        send_word(pfa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        send_word(pfa_pkg::CMD_FREE, 32'd0);
        send_word(pfa_pkg::CMD_FREE, 32'h7FFF_F000);
        send_word(pfa_pkg::CMD_FREE, 32'h8800_0000);
        send_word(pfa_pkg::CMD_FREE, 32'h8000_0800);
        send_word(pfa_pkg::CMD_FREE, 32'h8000_1000);
        send_word(pfa_pkg::CMD_FREE, 32'h8000_1000);   // double free
        send_word(pfa_pkg::CMD_ALLOC, 32'd0);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF);
        send_word(pfa_pkg::CMD_INIT, 32'd0);
        send_word(pfa_pkg::CMD_ALLOC, 32'd0);
        wait_idle();

        // Region at the top of the address space: allocation wraps
        write_regs(32'hFFFF_F000, 32'd0);
        send_word(pfa_pkg::CMD_INIT, 32'd0);
        send_word(pfa_pkg::CMD_ALLOC, 32'd0);
        send_word(pfa_pkg::CMD_ALLOC, 32'd0);
        send_word(pfa_pkg::CMD_FREE, 32'hFFFF_FFFF);
        send_word(pfa_pkg::CMD_FREE, 32'h0000_1000);
        send_word(pfa_pkg::CMD_FREE, 32'hFFFF_F000);
        wait_idle();

        // Region at zero, reserved count above the page count: full map
        write_regs(32'd0, 32'hFFFF_FFFF);
        send_word(pfa_pkg::CMD_INIT, 32'd0);
        send_word(pfa_pkg::CMD_ALLOC, 32'd0);
        send_word(pfa_pkg::CMD_FREE, 32'd0);
        send_word(pfa_pkg::CMD_FREE, 32'h0800_0000);
        send_word(pfa_pkg::CMD_FREE, 32'h07FF_F000);
        send_word(pfa_pkg::CMD_ALLOC, 32'd0);
        wait_idle();

        // Random phases, each under its own register setting
        while (random_words < RANDOM_WORDS)
        begin
            if (random_words < RANDOM_WORDS / 3)
            begin
                tx_idle_pct = 19;
                rx_idle_pct = 58;
            end
            else if (random_words < 2 * RANDOM_WORDS / 3)
            begin
                tx_idle_pct = 58;
                rx_idle_pct = 19;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case ($urandom_range(0, 5))
                0:       base = 32'd0;
                1:       base = 32'hFFFF_FFFF;
                2:       base = 32'hFFFF_F000;
                3:       base = pfa_pkg::REGION_BASE_RST;
                4:       base = $urandom & ~((32'd1 << PAGE_SHIFT) - 32'd1);
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 6))
                0:       resv = 16'd0;
                1:       resv = 16'(PAGE_COUNT);
                2:       resv = 16'(PAGE_COUNT - 1);
                3:       resv = 16'hFFFF;
                4:       resv = pfa_pkg::RESERVED_PAGES_RST;
                5:       resv = 16'($urandom_range(0, 400));
                default: resv = 16'($urandom_range(PAGE_COUNT - 60, PAGE_COUNT));
            endcase
            wait_idle();
            write_regs(base, {16'($urandom), resv});

            send_word(pfa_pkg::CMD_INIT, $urandom);
            random_words++;
            len = $urandom_range(40, 120);
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < 52)
                begin
                    send_word(pfa_pkg::CMD_ALLOC, $urandom);
                    random_words++;
                end
                else if (r < 90)
                begin
                    send_word(pfa_pkg::CMD_FREE, pick_free_addr());
                    random_words++;
                end
                else if (r < 95)
                begin
                    send_word(pfa_pkg::CMD_INIT, $urandom);
                    random_words++;
                end
                else
                begin
                    send_word(CMD_UNUSED, $urandom);
                end
            end
        end

        // Drain and verdict
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
